/* hw/rtl/hcrm_pkg.sv */
// Shared types, constants and register codes for the HSV color range mask block.
`timescale 1ns / 1ps

package hcrm_pkg;

  localparam int PIX_W  = 8;
  localparam int HUE_W  = 9;
  localparam int NUM_W  = 15;
  localparam int DIV_W  = 9;
  localparam int QUO_W  = 6;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Cycles from the accepting edge to the edge that ends the result cycle:
  // front register, queue entry, the divider stages and the output register.
  localparam int LATENCY = QUO_W + 3;

  localparam logic [NUM_W-1:0] HUE_MUL = NUM_W'(120);

  localparam logic [HUE_W-1:0] HUE_BASE_RED_UP  = HUE_W'(0);
  localparam logic [HUE_W-1:0] HUE_BASE_YELLOW  = HUE_W'(60);
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN   = HUE_W'(120);
  localparam logic [HUE_W-1:0] HUE_BASE_CYAN    = HUE_W'(180);
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE    = HUE_W'(240);
  localparam logic [HUE_W-1:0] HUE_BASE_MAGENTA = HUE_W'(300);

  localparam logic [HUE_W-1:0] HUE_ZERO    = HUE_W'(0);
  localparam logic [HUE_W-1:0] HUE_FULL    = HUE_W'(360);
  localparam logic [HUE_W-1:0] RED_LO      = HUE_W'(330);
  localparam logic [HUE_W-1:0] RED_HI      = HUE_W'(40);
  localparam logic [HUE_W-1:0] YELLOW_LO   = HUE_W'(40);
  localparam logic [HUE_W-1:0] YELLOW_HI   = HUE_W'(65);
  localparam logic [HUE_W-1:0] GREEN_LO    = HUE_W'(70);
  localparam logic [HUE_W-1:0] GREEN_HI    = HUE_W'(155);
  localparam logic [HUE_W-1:0] CYAN_LO     = HUE_W'(150);
  localparam logic [HUE_W-1:0] CYAN_HI     = HUE_W'(190);
  localparam logic [HUE_W-1:0] BLUE_LO     = HUE_W'(185);
  localparam logic [HUE_W-1:0] BLUE_HI     = HUE_W'(270);
  localparam logic [HUE_W-1:0] MAGENTA_LO  = HUE_W'(265);
  localparam logic [HUE_W-1:0] MAGENTA_HI  = HUE_W'(330);

  localparam logic [PIX_W-1:0] VALUE_HI    = PIX_W'(200);
  localparam logic [PIX_W-1:0] VALUE_LO    = PIX_W'(100);
  localparam logic [PIX_W-1:0] FULL_SELECT = PIX_W'(255);
  localparam logic [PIX_W-1:0] NO_SELECT   = PIX_W'(0);

  typedef enum logic [3:0] {
    CLS_RED       = 4'd0,
    CLS_YELLOW    = 4'd1,
    CLS_GREEN     = 4'd2,
    CLS_CYAN      = 4'd3,
    CLS_BLUE      = 4'd4,
    CLS_MAGENTA   = 4'd5,
    CLS_HIGHLIGHT = 4'd6,
    CLS_MIDTONE   = 4'd7,
    CLS_SHADOW    = 4'd8
  } range_class_t;

  localparam logic [1:0] REG_RANGE_CLASS   = 2'd0;
  localparam logic [1:0] REG_INVERT_SELECT = 2'd1;
  localparam logic [1:0] REG_SUBTRACT_MODE = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_alpha;
    logic [PIX_W-1:0] current_selectedness;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] new_selectedness;
    logic             mask_written;
  } out_t;

  // One classified pixel waiting for the hue division and band test.
  typedef struct packed {
    logic             has_hue;
    logic [HUE_W-1:0] hue_base;
    logic [NUM_W-1:0] numer;
    logic [DIV_W-1:0] divisor;
    logic [PIX_W-1:0] value;
    logic             opaque;
    logic [PIX_W-1:0] cur;
  } work_t;

  typedef struct packed {
    logic [3:0] range_class;
    logic       invert_select;
    logic       subtract_mode;
  } cfg_t;

endpackage

/* hw/rtl/hsv_color_range_mask_update_top.sv */
// Top level of the HSV color range mask update block with its register port.
`timescale 1ns / 1ps

// The block takes one RGBA pixel and the stored selection value per item and
// returns the mask value to write back, plus a flag that says it was rewritten.
// Input channel: an item is taken at each rising edge with start high and busy
// low. The front part converts the pixel and parks it in a short queue; the
// back part runs a six-stage restoring divider for the hue and then tests the
// configured band. Every stage moves each cycle, so one item per clock is
// sustained and busy stays low in normal operation.
// Result channel: out_valid is high for exactly one cycle per item, in order,
// and the result is taken at the edge that ends that cycle. The receiver cannot
// stall, so no backpressure reaches the pipeline.
// Path: an accepted item passes the front register, the queue entry and the
// six divider stages, then the output register drives the result ports.
// Configuration: APB writes at byte addresses 0, 4 and 8 set range_class,
// invert_select and subtract_mode. Write them only while no item is in flight.
// Reset (synchronous, active low) clears the registers to zero, empties the
// queue and pipeline, and holds busy high while it is asserted.
module hsv_color_range_mask_update_top import hcrm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_write;
  logic  accept;
  logic  push;
  work_t front_work;
  work_t head;
  logic  q_empty;
  logic  q_full;
  logic  pop;

  // Register file.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (paddr[3:2])
        REG_RANGE_CLASS:   cfg_nxt.range_class   = pwdata[3:0];
        REG_INVERT_SELECT: cfg_nxt.invert_select = pwdata[0];
        REG_SUBTRACT_MODE: cfg_nxt.subtract_mode = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_CLASS:   prdata = DATA_W'(cfg_r.range_class);
      REG_INVERT_SELECT: prdata = DATA_W'(cfg_r.invert_select);
      REG_SUBTRACT_MODE: prdata = DATA_W'(cfg_r.subtract_mode);
      default:           prdata = '0;
    endcase
  end

  // The queue only fills if the back part stops, which it never does.
  assign busy   = !rst_n || q_full;
  assign accept = start && !busy;

  hcrm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (in_data),
    .push_o   (push),
    .work_o   (front_work)
  );

  hcrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (front_work),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  hcrm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .cfg_i        (cfg_r),
    .pop_o        (pop),
    .out_valid_o  (out_valid),
    .out_data_o   (out_data)
  );

endmodule

/* hw/rtl/hcrm_front.sv */
// Front part: takes a pixel, finds max, min and the hue sector, forms the division operands.
`timescale 1ns / 1ps

module hcrm_front import hcrm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept_i,
  input  in_t   item_i,
  output logic  push_o,
  output work_t work_o
);

  logic [PIX_W-1:0] r, g, b;
  logic [PIX_W-1:0] mx, mn, d, n;
  logic [HUE_W-1:0] base;
  logic             valid_r;
  work_t            work_r;
  work_t            work_nxt;

  assign r = item_i.pixel_red;
  assign g = item_i.pixel_green;
  assign b = item_i.pixel_blue;

  // Red wins ties for the largest channel, then green.
  always_comb begin
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (r >= g && r >= b) begin
      mx = r;
    end else if (g >= b) begin
      mx = g;
    end else begin
      mx = b;
    end
    d = mx - mn;
    if (r >= g && r >= b) begin
      if (g >= b) begin
        n    = g - b;
        base = HUE_BASE_RED_UP;
      end else begin
        n    = d - (b - g);
        base = HUE_BASE_MAGENTA;
      end
    end else if (g >= b) begin
      if (b > r) begin
        n    = b - r;
        base = HUE_BASE_GREEN;
      end else begin
        n    = d - (r - b);
        base = HUE_BASE_YELLOW;
      end
    end else begin
      if (r > g) begin
        n    = r - g;
        base = HUE_BASE_BLUE;
      end else begin
        n    = d - (g - r);
        base = HUE_BASE_CYAN;
      end
    end
  end

  always_comb begin
    work_nxt.has_hue  = (d != '0);
    work_nxt.hue_base = base;
    work_nxt.numer    = NUM_W'(n) * HUE_MUL + NUM_W'(d);
    work_nxt.divisor  = {d, 1'b0};
    work_nxt.value    = mx;
    work_nxt.opaque   = (item_i.pixel_alpha != '0);
    work_nxt.cur      = item_i.current_selectedness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept_i;
    end
    work_r <= work_nxt;
  end

  assign push_o = valid_r;
  assign work_o = work_r;

endmodule

/* hw/rtl/hcrm_queue.sv */
// Short queue of classified pixels between the front and back parts.
`timescale 1ns / 1ps

module hcrm_queue import hcrm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  work_t data_i,
  input  logic  pop_i,
  output work_t data_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_i) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

/* hw/rtl/hcrm_back.sv */
// Back part: pipelined hue division, band test and mask value update.
`timescale 1ns / 1ps

module hcrm_back import hcrm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  work_t head_i,
  input  logic  head_valid_i,
  input  cfg_t  cfg_i,
  output logic  pop_o,
  output logic  out_valid_o,
  output out_t  out_data_o
);

  typedef struct packed {
    logic             valid;
    work_t            work;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

  div_stage_t       stage_r   [QUO_W];
  div_stage_t       stage_nxt [QUO_W];
  div_stage_t       last;
  logic [HUE_W-1:0] hue;
  logic             in_band;
  logic             match;
  logic             out_valid_r;
  out_t             out_r, out_nxt;

  // The back part never stalls, so it drains the queue every cycle.
  assign pop_o = head_valid_i;

  // One restoring quotient bit per stage, most significant first.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    div_stage_t       src;
    div_stage_t       nxt;
    logic [NUM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src = '{valid: head_valid_i, work: head_i, rem: head_i.numer, quo: '0};
    end else begin : g_next
      assign src = stage_r[k-1];
    end

    assign trial = NUM_W'(src.work.divisor) << (QUO_W - 1 - k);

    always_comb begin
      nxt = src;
      if (src.rem >= trial) begin
        nxt.rem                = src.rem - trial;
        nxt.quo[QUO_W - 1 - k] = 1'b1;
      end
    end

    assign stage_nxt[k] = nxt;
  end

  assign last = stage_r[QUO_W-1];
  assign hue  = last.work.hue_base + HUE_W'(last.quo);

  always_comb begin
    unique case (cfg_i.range_class)
      CLS_RED:       in_band = last.work.has_hue &&
                               ((hue > RED_LO && hue < HUE_FULL) ||
                                (hue > HUE_ZERO && hue < RED_HI));
      CLS_YELLOW:    in_band = last.work.has_hue && hue > YELLOW_LO && hue < YELLOW_HI;
      CLS_GREEN:     in_band = last.work.has_hue && hue > GREEN_LO && hue < GREEN_HI;
      CLS_CYAN:      in_band = last.work.has_hue && hue > CYAN_LO && hue < CYAN_HI;
      CLS_BLUE:      in_band = last.work.has_hue && hue > BLUE_LO && hue < BLUE_HI;
      CLS_MAGENTA:   in_band = last.work.has_hue && hue > MAGENTA_LO && hue < MAGENTA_HI;
      CLS_HIGHLIGHT: in_band = last.work.value > VALUE_HI;
      CLS_MIDTONE:   in_band = last.work.value > VALUE_LO && last.work.value < VALUE_HI;
      CLS_SHADOW:    in_band = last.work.value < VALUE_LO;
      default:       in_band = 1'b0;
    endcase
  end

  // A match writes full selection when invert_select equals subtract_mode, else zero.
  always_comb begin
    match                   = last.work.opaque && in_band;
    out_nxt.mask_written    = match;
    out_nxt.new_selectedness = last.work.cur;
    if (match) begin
      out_nxt.new_selectedness = (cfg_i.invert_select == cfg_i.subtract_mode) ?
                                 FULL_SELECT : NO_SELECT;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      stage_r[k].work <= stage_nxt[k].work;
      stage_r[k].rem  <= stage_nxt[k].rem;
      stage_r[k].quo  <= stage_nxt[k].quo;
    end
    out_r <= out_nxt;
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) begin
        stage_r[k].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < QUO_W; k++) begin
        stage_r[k].valid <= stage_nxt[k].valid;
      end
      out_valid_r <= last.valid;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

endmodule

/* hw/rtl/hcrm_checker.sv */
// Port-level checks for the HSV color range mask block and their binding.
`timescale 1ns / 1ps

module hcrm_checker import hcrm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // Every accepted item produces its result a fixed time later.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted item produced no result at the expected latency");

  // No result appears without an item accepted at the matching edge.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted item");

  // A rewritten value is either full selection or cleared.
  a_written_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mask_written |->
      (out_data.new_selectedness == FULL_SELECT ||
       out_data.new_selectedness == NO_SELECT))
    else $error("rewritten mask value is neither full nor empty");

  // A pixel left alone keeps the selection value it came in with.
  a_kept_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mask_written |->
      out_data.new_selectedness == $past(in_data.current_selectedness, LATENCY))
    else $error("unmatched pixel changed its selection value");

endmodule

bind hsv_color_range_mask_update_top hcrm_checker u_hcrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
